// ----- hdl/assert_macros.svh -----
// Assertion helpers. Users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while in reset.
`define FFHA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");

// Consequence must hold in the cycle after the trigger.
`define FFHA_ASSERT_NEXT(label, trig, cons) \
	`FFHA_ASSERT(label, (trig) |=> (cons))

`endif

// ----- hdl/ffha_pkg.sv -----
package ffha_pkg;

	localparam int ADDR_W     = 20;
	localparam int HEAP_W     = 20;
	localparam int HDR_W      = 7;
	localparam int MAX_SEG    = 64;
	localparam int SEG_IDX_W  = $clog2(MAX_SEG);
	localparam int SEG_CNT_W  = $clog2(MAX_SEG + 1);
	localparam int SUM_W      = ADDR_W + 2;
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
	localparam logic [ST_W-1:0] ST_BADADDR = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd1;

	localparam logic [HEAP_W-1:0] HEAP_RESET = 20'd250000;
	localparam logic [HDR_W-1:0]  HDR_RESET  = 7'd24;

	localparam logic MODE_ALLOC = 1'b0;

	localparam int SEG_W = 2 * ADDR_W + 1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic              free;
	} seg_t;

	typedef struct packed {
		logic                 we;
		logic [SEG_IDX_W-1:0] wr_addr;
		seg_t                 wr_data;
		logic [SEG_IDX_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [HDR_W-1:0]  c;
		logic [ADDR_W-1:0] x;
		logic [ADDR_W-1:0] y;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             x_ge_y;
		logic             x_eq_y;
		logic             x_gt_sum;
		logic             sum_eq_x;
	} alu_rsp_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ADDR_W-1:0] granted;
	} res_t;

endpackage

// ----- hdl/first_fit_heap_allocator.sv -----
// First-fit heap allocator with split and coalesce. The heap of heap_size bytes is kept as
// an address-ordered table of up to 64 segments (start, payload size, free flag), each
// behind a header of header_bytes. The table is built on the first request after reset or
// after any register write, as one free segment; a register write thus discards every
// earlier allocation. mode 0 allocates request_bytes from the first free segment large
// enough: an exact fit is taken whole, a larger one is split into a used front part and a
// free rest, and a segment that is larger by no more than one header fails with status 1.
// mode 1 frees the segment whose payload starts at payload_address and merges all runs of
// adjacent free segments. status: 0 ok, 1 no fitting segment, 2 address not a segment,
// 3 table full (a split needs a new entry while all 64 are used). granted_address is the
// payload offset of an allocation and 0 otherwise. Requests are served one at a time.
// The table lives in a memory with one read and one write port, read one entry per clock,
// so cost follows the number of entries N. An allocate scans from entry 0 until it stops
// (fit, too small or table full); a split then runs a move-up pass over the entries above
// the hit and writes the two entries. An allocate with no fit or a free of an unknown
// address scans the whole table; a free of a known entry searches for it, then makes one
// compaction pass over the whole table. One result register sits on the output, so the
// next request is taken while a result still waits; a stalled output adds its stall
// cycles only when a second result is ready behind it. No clearing pass follows reset.
module first_fit_heap_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [ffha_pkg::ADDR_W-1:0]       request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0]       payload_address,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ffha_pkg::ST_W-1:0]         status,
	output logic [ffha_pkg::ADDR_W-1:0]       granted_address,
	// register writes
	input  logic                              cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffha_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import ffha_pkg::*;

	logic [HEAP_W-1:0] heap_size_q;
	logic [HDR_W-1:0]  header_bytes_q;
	logic              cfg_clr;

	mem_req_t          mem_req;
	logic [SEG_W-1:0]  rd_bits;
	seg_t              rd_data;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	logic              res_valid;
	logic              res_take;
	res_t              res;

	logic              out_valid_q;
	res_t              out_q;

	// geometry registers; any write to a known index forces a rebuild
	assign cfg_clr = cfg_we && (cfg_index == CFG_HEAP_SIZE || cfg_index == CFG_HEADER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q    <= HEAP_RESET;
			header_bytes_q <= HDR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEAP_SIZE:    heap_size_q    <= cfg_data[HEAP_W-1:0];
				CFG_HEADER_BYTES: header_bytes_q <= cfg_data[HDR_W-1:0];
				default:          ;
			endcase
		end
	end

	// segment table
	ffha_seg_ram #(
		.DEPTH (MAX_SEG),
		.WIDTH (SEG_W)
	) u_table (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.wr_addr),
		.wdata (mem_req.wr_data),
		.raddr (mem_req.rd_addr),
		.rdata (rd_bits)
	);

	assign rd_data = seg_t'(rd_bits);

	// shared adder / comparator
	ffha_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ffha_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.request_bytes   (request_bytes),
		.payload_address (payload_address),
		.heap_size       (heap_size_q),
		.header_bytes    (header_bytes_q),
		.cfg_clr         (cfg_clr),
		.mem_req         (mem_req),
		.rd_data         (rd_data),
		.alu_req         (alu_req),
		.alu_rsp         (alu_rsp),
		.res_valid       (res_valid),
		.res             (res),
		.res_take        (res_take)
	);

	// output register: a new result loads when the slot is empty or draining
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign granted_address = out_q.granted;

endmodule

// ----- hdl/ffha_seg_ram.sv -----
module ffha_seg_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 41
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/ffha_alu.sv -----
module ffha_alu (
	input  ffha_pkg::alu_req_t req,
	output ffha_pkg::alu_rsp_t rsp
);

	import ffha_pkg::*;

	// one adder, shared by fit, match, split and merge steps
	always_comb begin
		rsp.sum      = SUM_W'(req.a) + SUM_W'(req.b) + SUM_W'(req.c);
		rsp.x_ge_y   = (req.x >= req.y);
		rsp.x_eq_y   = (req.x == req.y);
		rsp.x_gt_sum = (SUM_W'(req.x) > rsp.sum);
		rsp.sum_eq_x = (rsp.sum == SUM_W'(req.x));
	end

endmodule

// ----- hdl/ffha_ctrl.sv -----
`include "assert_macros.svh"

module ffha_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [ffha_pkg::ADDR_W-1:0]   request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0]   payload_address,
	input  logic [ffha_pkg::HEAP_W-1:0]   heap_size,
	input  logic [ffha_pkg::HDR_W-1:0]    header_bytes,
	input  logic                          cfg_clr,
	output ffha_pkg::mem_req_t            mem_req,
	input  ffha_pkg::seg_t                rd_data,
	output ffha_pkg::alu_req_t            alu_req,
	input  ffha_pkg::alu_rsp_t            alu_rsp,
	output logic                          res_valid,
	output ffha_pkg::res_t                res,
	input  logic                          res_take
);

	import ffha_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN     = 4'd1;
	localparam logic [3:0] S_ALLOC    = 4'd2;
	localparam logic [3:0] S_SHIFT    = 4'd3;
	localparam logic [3:0] S_INSERT   = 4'd4;
	localparam logic [3:0] S_INSERT2  = 4'd5;
	localparam logic [3:0] S_COAL     = 4'd6;
	localparam logic [3:0] S_COAL_END = 4'd7;
	localparam logic [3:0] S_RESP     = 4'd8;

	logic [3:0]           state_q, state_d;
	logic                 table_ready_q, table_ready_d;
	logic [SEG_CNT_W-1:0] count_q, count_d;
	logic [SEG_CNT_W-1:0] rd_idx_q, rd_idx_d;
	logic                 pv_q, pv_d;
	logic [SEG_IDX_W-1:0] pidx_q, pidx_d;
	logic                 acc_v_q, acc_v_d;
	logic [SEG_IDX_W-1:0] wp_q, wp_d;

	logic                 mode_q, mode_d;
	logic [ADDR_W-1:0]    req_q, req_d;
	logic [ADDR_W-1:0]    paddr_q, paddr_d;
	logic [SEG_IDX_W-1:0] hit_idx_q, hit_idx_d;
	seg_t                 seg_q, seg_d;
	logic                 exact_q, exact_d;
	logic                 big_q, big_d;
	logic [ADDR_W:0]      reqhdr_q, reqhdr_d;
	seg_t                 new_q, new_d;
	seg_t                 acc_q, acc_d;
	res_t                 res_q, res_d;

	logic                 issue;
	logic                 last;
	seg_t                 ent;
	logic [HEAP_W-1:0]    build_size;

	assign res = res_q;

	always_comb begin
		state_d       = state_q;
		table_ready_d = table_ready_q;
		count_d       = count_q;
		rd_idx_d      = rd_idx_q;
		pv_d          = pv_q;
		pidx_d        = pidx_q;
		acc_v_d       = acc_v_q;
		wp_d          = wp_q;
		mode_d        = mode_q;
		req_d         = req_q;
		paddr_d       = paddr_q;
		hit_idx_d     = hit_idx_q;
		seg_d         = seg_q;
		exact_d       = exact_q;
		big_d         = big_q;
		reqhdr_d      = reqhdr_q;
		new_d         = new_q;
		acc_d         = acc_q;
		res_d         = res_q;

		mem_req         = '0;
		mem_req.rd_addr = rd_idx_q[SEG_IDX_W-1:0];
		alu_req         = '0;
		alu_req.c       = header_bytes;

		in_stall  = (state_q != S_IDLE);
		res_valid = (state_q == S_RESP);

		issue = (rd_idx_q < count_q);
		last  = ((SEG_CNT_W'(pidx_q) + SEG_CNT_W'(1)) == count_q);

		ent = rd_data;
		if (pidx_q == hit_idx_q) begin
			ent.free = 1'b1;
		end

		build_size = (heap_size > HEAP_W'(header_bytes)) ?
			(heap_size - HEAP_W'(header_bytes)) : '0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_d  = mode;
					req_d   = request_bytes;
					paddr_d = payload_address;
					if (!table_ready_q) begin
						mem_req.we            = 1'b1;
						mem_req.wr_addr       = '0;
						mem_req.wr_data.start = '0;
						mem_req.wr_data.size  = ADDR_W'(build_size);
						mem_req.wr_data.free  = 1'b1;
						count_d               = SEG_CNT_W'(1);
						table_ready_d         = 1'b1;
					end
					rd_idx_d = '0;
					pv_d     = 1'b0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				pv_d   = issue;
				pidx_d = rd_idx_q[SEG_IDX_W-1:0];
				if (issue) begin
					rd_idx_d = rd_idx_q + SEG_CNT_W'(1);
				end
				if (mode_q == MODE_ALLOC) begin
					alu_req.a = req_q;
					alu_req.x = rd_data.size;
					alu_req.y = req_q;
				end else begin
					alu_req.a = rd_data.start;
					alu_req.x = paddr_q;
				end
				if (pv_q) begin
					if (mode_q == MODE_ALLOC && rd_data.free && alu_rsp.x_ge_y) begin
						hit_idx_d = pidx_q;
						seg_d     = rd_data;
						exact_d   = alu_rsp.x_eq_y;
						big_d     = alu_rsp.x_gt_sum;
						reqhdr_d  = alu_rsp.sum[ADDR_W:0];
						state_d   = S_ALLOC;
					end else if (mode_q != MODE_ALLOC && alu_rsp.sum_eq_x) begin
						hit_idx_d = pidx_q;
						rd_idx_d  = '0;
						pv_d      = 1'b0;
						acc_v_d   = 1'b0;
						wp_d      = '0;
						state_d   = S_COAL;
					end else if (last) begin
						res_d.status  = (mode_q == MODE_ALLOC) ? ST_NOFIT : ST_BADADDR;
						res_d.granted = '0;
						state_d       = S_RESP;
					end
				end
			end
			S_ALLOC: begin
				if (exact_q) begin
					mem_req.we      = 1'b1;
					mem_req.wr_addr = hit_idx_q;
					mem_req.wr_data = '{start: seg_q.start, size: seg_q.size, free: 1'b0};
					alu_req.a       = seg_q.start;
					res_d.status    = ST_OK;
					res_d.granted   = alu_rsp.sum[ADDR_W-1:0];
					state_d         = S_RESP;
				end else if (big_q) begin
					if (count_q == SEG_CNT_W'(MAX_SEG)) begin
						res_d.status  = ST_FULL;
						res_d.granted = '0;
						state_d       = S_RESP;
					end else begin
						alu_req.a   = seg_q.start;
						alu_req.b   = req_q;
						new_d.start = alu_rsp.sum[ADDR_W-1:0];
						new_d.size  = seg_q.size - reqhdr_q[ADDR_W-1:0];
						new_d.free  = 1'b1;
						rd_idx_d    = count_q - SEG_CNT_W'(1);
						pv_d        = 1'b0;
						if (count_q == SEG_CNT_W'(hit_idx_q) + SEG_CNT_W'(1)) begin
							state_d = S_INSERT;
						end else begin
							state_d = S_SHIFT;
						end
					end
				end else begin
					res_d.status  = ST_NOFIT;
					res_d.granted = '0;
					state_d       = S_RESP;
				end
			end
			S_SHIFT: begin
				// move entries above the split up by one, top first
				if (pv_q) begin
					mem_req.we      = 1'b1;
					mem_req.wr_addr = pidx_q + SEG_IDX_W'(1);
					mem_req.wr_data = rd_data;
				end
				if (rd_idx_q > SEG_CNT_W'(hit_idx_q)) begin
					pv_d     = 1'b1;
					pidx_d   = rd_idx_q[SEG_IDX_W-1:0];
					rd_idx_d = rd_idx_q - SEG_CNT_W'(1);
				end else begin
					pv_d = 1'b0;
				end
				if (pv_q && pidx_q == hit_idx_q + SEG_IDX_W'(1)) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				mem_req.we      = 1'b1;
				mem_req.wr_addr = hit_idx_q + SEG_IDX_W'(1);
				mem_req.wr_data = new_q;
				count_d         = count_q + SEG_CNT_W'(1);
				state_d         = S_INSERT2;
			end
			S_INSERT2: begin
				mem_req.we      = 1'b1;
				mem_req.wr_addr = hit_idx_q;
				mem_req.wr_data = '{start: seg_q.start, size: req_q, free: 1'b0};
				alu_req.a       = seg_q.start;
				res_d.status    = ST_OK;
				res_d.granted   = alu_rsp.sum[ADDR_W-1:0];
				state_d         = S_RESP;
			end
			S_COAL: begin
				// compaction pass: runs of free entries fold into the pending one
				pv_d   = issue;
				pidx_d = rd_idx_q[SEG_IDX_W-1:0];
				if (issue) begin
					rd_idx_d = rd_idx_q + SEG_CNT_W'(1);
				end
				if (pv_q) begin
					alu_req.a = acc_q.size;
					alu_req.b = ent.size;
					if (!acc_v_q) begin
						acc_d   = ent;
						acc_v_d = 1'b1;
					end else if (acc_q.free && ent.free) begin
						acc_d.size = alu_rsp.sum[ADDR_W-1:0];
					end else begin
						mem_req.we      = 1'b1;
						mem_req.wr_addr = wp_q;
						mem_req.wr_data = acc_q;
						wp_d            = wp_q + SEG_IDX_W'(1);
						acc_d           = ent;
					end
					if (last) begin
						state_d = S_COAL_END;
					end
				end
			end
			S_COAL_END: begin
				mem_req.we      = 1'b1;
				mem_req.wr_addr = wp_q;
				mem_req.wr_data = acc_q;
				count_d         = SEG_CNT_W'(wp_q) + SEG_CNT_W'(1);
				res_d.status    = ST_OK;
				res_d.granted   = '0;
				state_d         = S_RESP;
			end
			S_RESP: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cfg_clr) begin
			table_ready_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			table_ready_q <= 1'b0;
			count_q       <= '0;
			rd_idx_q      <= '0;
			pv_q          <= 1'b0;
			pidx_q        <= '0;
			acc_v_q       <= 1'b0;
			wp_q          <= '0;
		end else begin
			state_q       <= state_d;
			table_ready_q <= table_ready_d;
			count_q       <= count_d;
			rd_idx_q      <= rd_idx_d;
			pv_q          <= pv_d;
			pidx_q        <= pidx_d;
			acc_v_q       <= acc_v_d;
			wp_q          <= wp_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q    <= mode_d;
		req_q     <= req_d;
		paddr_q   <= paddr_d;
		hit_idx_q <= hit_idx_d;
		seg_q     <= seg_d;
		exact_q   <= exact_d;
		big_q     <= big_d;
		reqhdr_q  <= reqhdr_d;
		new_q     <= new_d;
		acc_q     <= acc_d;
		res_q     <= res_d;
	end

	`FFHA_ASSERT(a_count_max, count_q <= SEG_CNT_W'(MAX_SEG))
	`FFHA_ASSERT(a_ready_count, table_ready_q |-> (count_q != '0))
	`FFHA_ASSERT(a_scan_no_write, (state_q == S_SCAN) |-> !mem_req.we)
	`FFHA_ASSERT(a_shift_above_hit, (state_q == S_SHIFT && mem_req.we) |-> (mem_req.wr_addr > hit_idx_q))
	`FFHA_ASSERT(a_coal_wp_behind, (state_q == S_COAL && pv_q) |-> (wp_q <= pidx_q))
	`FFHA_ASSERT_NEXT(a_insert_grows, (state_q == S_INSERT), (count_q == $past(count_q) + SEG_CNT_W'(1)))

endmodule

// ----- verif/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the first-fit heap allocator.
// An initial block queues allocate/free requests; a clocked driver presents them, and on
// every accepted request it updates a shadow of the segment table and queues the
// expected status/granted_address. A clocked monitor checks each accepted result
// against the oldest expectation.
module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam logic MODE_FREE = 1'b1;
	// indexes that map to no register: a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	// pad generously beyond the worst request
	localparam int SETTLE_CYCLES = 2 * MAX_SEG + 40;
	// cycles with work pending but no handshake on either side
	localparam int QUIET_LIMIT = 5000;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] bytes;
		logic [ADDR_W-1:0] addr;
	} heap_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  mode = MODE_ALLOC;
	logic [ADDR_W-1:0]     request_bytes = '0;
	logic [ADDR_W-1:0]     payload_address = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ST_W-1:0]       status;
	logic [ADDR_W-1:0]     granted_address;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEAP_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	heap_req_t         pending_reqs[$];
	res_t              expected_results[$];
	// payload addresses of segments currently in use, fed back into free requests
	logic [ADDR_W-1:0] used_addrs[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;

	// shadow segment table and geometry
	logic [ADDR_W-1:0] seg_base [MAX_SEG];
	logic [ADDR_W-1:0] seg_len  [MAX_SEG];
	logic              seg_open [MAX_SEG];
	int                seg_total = 0;
	logic              layout_built = 1'b0;
	logic [HEAP_W-1:0] heap_bytes = HEAP_RESET;
	logic [HDR_W-1:0]  hdr_bytes = HDR_RESET;

	first_fit_heap_allocator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.request_bytes  (request_bytes),
		.payload_address(payload_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_address(granted_address),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Random value over a full address-wide field.
	function automatic logic [ADDR_W-1:0] rnd_field();
		return ADDR_W'($urandom);
	endfunction

	// Serve one request against the shadow table; returns the expected result.
	function automatic res_t serve_request(heap_req_t rq);
		res_t              r;
		int                i;
		longint            payload;
		logic [ADDR_W-1:0] hdr;
		r.status  = ST_OK;
		r.granted = '0;
		hdr       = ADDR_W'(hdr_bytes);
		// table is built lazily, for a free request as well
		if (!layout_built) begin
			payload = 0;
			if (heap_bytes > HEAP_W'(hdr_bytes))
				payload = longint'(heap_bytes - HEAP_W'(hdr_bytes));
			seg_base[0]  = '0;
			seg_len[0]   = ADDR_W'(payload);
			seg_open[0]  = 1'b1;
			seg_total    = 1;
			layout_built = 1'b1;
		end
		if (rq.mode == MODE_ALLOC) begin
			i = 0;
			while (i < seg_total && !(seg_open[i] && seg_len[i] >= rq.bytes))
				i++;
			if (i == seg_total) begin
				r.status = ST_NOFIT;
			end else if (seg_len[i] == rq.bytes) begin
				seg_open[i] = 1'b0;
				r.granted   = seg_base[i] + hdr;
			end else if (longint'(seg_len[i]) <= longint'(rq.bytes) + longint'(hdr_bytes)) begin
				// larger than the request, but the rest could hold no more than a header
				r.status = ST_NOFIT;
			end else if (seg_total >= MAX_SEG) begin
				r.status = ST_FULL;
			end else begin
				for (int k = seg_total; k > i + 1; k--) begin
					seg_base[k] = seg_base[k-1];
					seg_len[k]  = seg_len[k-1];
					seg_open[k] = seg_open[k-1];
				end
				seg_base[i+1] = seg_base[i] + hdr + rq.bytes;
				seg_len[i+1]  = seg_len[i] - rq.bytes - hdr;
				seg_open[i+1] = 1'b1;
				seg_len[i]    = rq.bytes;
				seg_open[i]   = 1'b0;
				seg_total++;
				r.granted = seg_base[i] + hdr;
			end
		end else begin
			// sum is formed wide, so a start near the top never aliases a low address
			i = 0;
			while (i < seg_total &&
				longint'(seg_base[i]) + longint'(hdr_bytes) != longint'(rq.addr))
				i++;
			if (i == seg_total) begin
				r.status = ST_BADADDR;
			end else begin
				seg_open[i] = 1'b1;
				// merge every run of free neighbors into its first entry
				i = 0;
				while (i + 1 < seg_total) begin
					if (seg_open[i] && seg_open[i+1]) begin
						seg_len[i] = seg_len[i] + seg_len[i+1] + hdr;
						for (int k = i + 1; k + 1 < seg_total; k++) begin
							seg_base[k] = seg_base[k+1];
							seg_len[k]  = seg_len[k+1];
							seg_open[k] = seg_open[k+1];
						end
						seg_total--;
					end else begin
						i++;
					end
				end
			end
		end
		return r;
	endfunction

	// Random free segment of the shadow table, -1 if none.
	function automatic int open_slot();
		int hits[$];
		for (int k = 0; k < seg_total; k++)
			if (seg_open[k])
				hits.push_back(k);
		return (hits.size() != 0) ? hits[$urandom_range(hits.size() - 1)] : -1;
	endfunction

	// Request driver: prediction happens at the accepting edge.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		heap_req_t taken;
		heap_req_t nxt;
		res_t      want;
		if (!arst_n) begin
			in_valid        <= 1'b0;
			mode            <= MODE_ALLOC;
			request_bytes   <= '0;
			payload_address <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				taken.mode  = mode;
				taken.bytes = request_bytes;
				taken.addr  = payload_address;
				want = serve_request(taken);
				expected_results.push_back(want);
				if (want.status == ST_OK) begin
					if (mode == MODE_ALLOC) begin
						used_addrs.push_back(want.granted);
					end else begin
						for (int j = 0; j < used_addrs.size(); j++) begin
							if (used_addrs[j] == payload_address) begin
								used_addrs.delete(j);
								break;
							end
						end
					end
				end
			end
			// payload only moves once the current request is gone
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_reqs.pop_front();
					in_valid        <= 1'b1;
					mode            <= nxt.mode;
					request_bytes   <= nxt.bytes;
					payload_address <= nxt.addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and random back-pressure.
	always @(posedge clk or negedge arst_n) begin : check_results
		res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got status %0d addr 0x%05h",
						$time, status, granted_address);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d, got %0d", $time, want.status, status);
					end
					if (granted_address !== want.granted) begin
						errors++;
						$display("%0t: granted_address expected 0x%05h, got 0x%05h",
							$time, want.granted, granted_address);
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: only counts while something is still owed.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(!in_valid && pending_reqs.size() == 0 && expected_results.size() == 0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Keeps the driver queue short so free requests see fresh addresses.
	task automatic enqueue(logic m, logic [ADDR_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
		heap_req_t rq;
		while (pending_reqs.size() > 1)
			@(posedge clk);
		rq.mode  = m;
		rq.bytes = nbytes;
		rq.addr  = addr;
		pending_reqs.push_back(rq);
	endtask

	// Hold the sender until every result is back, then let the block go quiet.
	task automatic settle();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		// a real register write throws the table away
		if (idx == CFG_HEAP_SIZE) begin
			heap_bytes   = data;
			layout_built = 1'b0;
			used_addrs.delete();
		end else if (idx == CFG_HEADER_BYTES) begin
			hdr_bytes    = data[HDR_W-1:0];
			layout_built = 1'b0;
			used_addrs.delete();
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed traffic: frees of live addresses, exact fits, near misses.
	task automatic queue_random(int count, int alloc_pct, int size_cap);
		logic              m;
		logic [ADDR_W-1:0] nbytes;
		logic [ADDR_W-1:0] addr;
		int                slot;
		for (int n = 0; n < count; n++) begin
			m      = MODE_ALLOC;
			nbytes = ADDR_W'($urandom_range(size_cap));
			addr   = rnd_field();
			slot   = open_slot();
			case ($urandom_range(19))
				0: begin
					// noise over the full field ranges
					m      = ($urandom_range(1) != 0) ? MODE_FREE : MODE_ALLOC;
					nbytes = rnd_field();
				end
				1, 2: begin
					if (slot >= 0)
						nbytes = seg_len[slot];
				end
				3: begin
					// just over the request but too small to carry a new header
					if (slot >= 0 && seg_len[slot] > ADDR_W'(hdr_bytes))
						nbytes = seg_len[slot] - ADDR_W'($urandom_range(1, hdr_bytes));
				end
				default: begin
					if ($urandom_range(99) >= alloc_pct && used_addrs.size() != 0) begin
						m      = MODE_FREE;
						nbytes = rnd_field();
						addr   = used_addrs[$urandom_range(used_addrs.size() - 1)];
						case ($urandom_range(9))
							0: if (slot >= 0) addr = seg_base[slot] + ADDR_W'(hdr_bytes);
							1: addr = ($urandom_range(1) != 0) ? addr + ADDR_W'(1) :
								addr - ADDR_W'(1);
							default: ;
						endcase
					end
				end
			endcase
			enqueue(m, nbytes, addr);
		end
	endtask

	// One geometry; a quiet point halfway with a write to an unused index.
	task automatic run_phase(int heap, int hdr, int idle, int stall, int count,
		int alloc_pct, int size_cap);
		settle();
		write_reg(CFG_HEAP_SIZE, CFG_DATA_W'(heap));
		write_reg(CFG_HEADER_BYTES, CFG_DATA_W'(hdr));
		idle_pct  = idle;
		stall_pct = stall;
		queue_random(count / 2, alloc_pct, size_cap);
		settle();
		write_reg(($urandom_range(1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
			CFG_DATA_W'($urandom));
		queue_random(count - count / 2, alloc_pct, size_cap);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset geometry (heap 250000, header 24).
		enqueue(MODE_FREE, rnd_field(), 20'd24);       // free before the table exists
		enqueue(MODE_ALLOC, 20'd0, rnd_field());       // zero-byte split at the front
		enqueue(MODE_ALLOC, 20'hFFFFF, rnd_field());   // largest request: no fit
		enqueue(MODE_FREE, rnd_field(), 20'hFFFFF);    // not a payload start
		enqueue(MODE_ALLOC, 20'd100, rnd_field());
		enqueue(MODE_ALLOC, 20'd50, rnd_field());
		enqueue(MODE_FREE, rnd_field(), 20'd24);
		enqueue(MODE_FREE, rnd_field(), 20'd24);       // already free: still ok
		enqueue(MODE_ALLOC, 20'd0, rnd_field());       // exact fit on the zero-size segment
		enqueue(MODE_FREE, rnd_field(), 20'd48);       // hole of 100 between used neighbors
		enqueue(MODE_ALLOC, 20'd90, rnd_field());      // rest would be under a header
		enqueue(MODE_ALLOC, 20'd76, rnd_field());      // rest exactly one header: no fit
		enqueue(MODE_ALLOC, 20'd75, rnd_field());      // leaves a 1-byte segment
		enqueue(MODE_ALLOC, 20'd1, rnd_field());       // exact fit on it
		enqueue(MODE_FREE, rnd_field(), 20'd172);      // merges with the tail
		enqueue(MODE_FREE, rnd_field(), 20'd147);      // merges again
		enqueue(MODE_FREE, rnd_field(), 20'd0);        // below any payload
		enqueue(MODE_ALLOC, 20'h80000, rnd_field());
		enqueue(MODE_FREE, rnd_field(), 20'd48);

		// heap, header, idle %, stall %, requests, alloc %, size cap
		run_phase(4096, 8, 0, 0, 400, 70, 120);
		run_phase(1048575, 1, 80, 0, 320, 75, 40000);
		run_phase(64, 64, 0, 80, 40, 60, 4);           // heap no bigger than a header
		run_phase(600, 1, 0, 80, 350, 65, 12);         // small pieces: fills the table
		run_phase(250000, 24, 31, 31, 360, 60, 8000);

		settle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
